@@ sv/cdq_pkg.sv @@
// Package for the circular deque: sizes, codes, RAM command type and helpers.
`default_nettype none
package cdq_pkg;

    // Store geometry
    localparam int DEPTH     = 8;
    localparam int WORD_BITS = 32;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);

    // Field widths of the channels
    localparam int VAL_W = 32;

    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [WORD_BITS-1:0] t_word;

    typedef enum logic [1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_BACK  = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_BACK   = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2
    } t_status;

    // Command from the controller to the entry RAM
    typedef struct packed {
        logic  we;
        t_idx  waddr;
        t_word wdata;
        logic  re;
        t_idx  raddr;
    } t_ram_cmd;

    localparam t_idx IDX_LAST  = t_idx'(DEPTH - 1);
    localparam t_cnt CNT_DEPTH = t_cnt'(DEPTH);

    // Index one step up, wrapping at the end of the store
    function automatic t_idx idx_up(input t_idx i);
        return (i >= IDX_LAST) ? '0 : t_idx'(i + 1'b1);
    endfunction

    // Index one step down, wrapping at the start of the store
    function automatic t_idx idx_down(input t_idx i);
        return (i == '0 || i > IDX_LAST) ? IDX_LAST : t_idx'(i - 1'b1);
    endfunction

    // Keep the low WORD_BITS bits of a push value
    function automatic t_word to_word(input logic [VAL_W-1:0] v);
        t_word w;
        w = '0;
        for (int i = 0; i < WORD_BITS && i < VAL_W; i++) begin
            w[i] = v[i];
        end
        return w;
    endfunction

    // Zero-extend or truncate a stored word to the pop value width
    function automatic logic [VAL_W-1:0] from_word(input t_word w);
        logic [VAL_W-1:0] v;
        v = '0;
        for (int i = 0; i < WORD_BITS && i < VAL_W; i++) begin
            v[i] = w[i];
        end
        return v;
    endfunction

endpackage
`default_nettype wire

@@ sv/cdq_req_if.sv @@
// Request channel: request type and push word with valid/ready.
`default_nettype none
interface cdq_req_if;
    logic                                valid;
    logic                                ready;
    cdq_pkg::t_req_type                  req_type;
    logic signed [cdq_pkg::VAL_W-1:0]    push_value;

    modport source (output valid, output req_type, output push_value, input ready);
    modport sink   (input valid, input req_type, input push_value, output ready);
endinterface
`default_nettype wire

@@ sv/cdq_rsp_if.sv @@
// Response channel: popped word, status and fill flags with valid/ready.
`default_nettype none
interface cdq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [cdq_pkg::VAL_W-1:0]    pop_value;
    cdq_pkg::t_status                    status;
    logic                                now_empty;
    logic                                now_full;

    modport source (output valid, output pop_value, output status,
                    output now_empty, output now_full, input ready);
    modport sink   (input valid, input pop_value, input status,
                    input now_empty, input now_full, output ready);
endinterface
`default_nettype wire

@@ sv/cdq_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module cdq_ram #(
    parameter int DEPTH_P = 8,
    parameter int WIDTH_P = 32,
    parameter int AW_P    = (DEPTH_P > 1) ? $clog2(DEPTH_P) : 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_we,
    input  wire logic [AW_P-1:0]    i_waddr,
    input  wire logic [WIDTH_P-1:0] i_wdata,
    input  wire logic               i_re,
    input  wire logic [AW_P-1:0]    i_raddr,
    output logic      [WIDTH_P-1:0] o_rdata
);

    logic [WIDTH_P-1:0] r_mem [DEPTH_P];
    logic [WIDTH_P-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data, holds between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ sv/cdq_ctrl.sv @@
// Deque controller: head/tail/count registers, request decode, result register.
`default_nettype none
module cdq_ctrl (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    cdq_req_if.sink         i_req,
    cdq_rsp_if.source       o_rsp,
    output cdq_pkg::t_ram_cmd o_ram_cmd,
    input  wire cdq_pkg::t_word i_rd_data
);
    import cdq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_POP  = 2'b10
    } t_state;

    t_state  r_state, n_state;
    t_idx    r_head, n_head;
    t_idx    r_tail, n_tail;
    t_cnt    r_count, n_count;
    logic    r_out_valid, n_out_valid;

    logic [VAL_W-1:0] r_pop_value, n_pop_value;
    t_status          r_status, n_status;
    logic             r_empty, n_empty;
    logic             r_full, n_full;

    t_ram_cmd ram_cmd;
    logic     req_fire;
    logic     is_full;
    logic     is_empty;
    logic     is_push;

    // Take a new item only when idle and the result slot frees up
    assign i_req.ready = r_state[0] && (!r_out_valid || o_rsp.ready);
    assign req_fire    = i_req.valid && i_req.ready;
    assign is_full     = (r_count >= CNT_DEPTH);
    assign is_empty    = (r_count == '0);
    assign is_push     = (i_req.req_type == REQ_PUSH_FRONT) ||
                         (i_req.req_type == REQ_PUSH_BACK);

    // Request decode and pointer update
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_pop_value = r_pop_value;
        n_status    = r_status;
        n_empty     = r_empty;
        n_full      = r_full;
        ram_cmd     = '0;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (req_fire) begin
                    n_status    = STAT_OK;
                    n_pop_value = '0;
                    n_out_valid = 1'b1;
                    case (i_req.req_type)
                        REQ_PUSH_FRONT: begin
                            if (is_full) begin
                                n_status = STAT_OVERFLOW;
                            end else begin
                                n_head        = idx_down(r_head);
                                ram_cmd.we    = 1'b1;
                                ram_cmd.waddr = idx_down(r_head);
                                ram_cmd.wdata = to_word(i_req.push_value);
                                n_count       = t_cnt'(r_count + 1'b1);
                            end
                        end
                        REQ_PUSH_BACK: begin
                            if (is_full) begin
                                n_status = STAT_OVERFLOW;
                            end else begin
                                ram_cmd.we    = 1'b1;
                                ram_cmd.waddr = r_tail;
                                ram_cmd.wdata = to_word(i_req.push_value);
                                n_tail        = idx_up(r_tail);
                                n_count       = t_cnt'(r_count + 1'b1);
                            end
                        end
                        REQ_POP_FRONT: begin
                            if (is_empty) begin
                                n_status = STAT_UNDERFLOW;
                            end else begin
                                ram_cmd.re    = 1'b1;
                                ram_cmd.raddr = r_head;
                                n_head        = idx_up(r_head);
                                n_count       = t_cnt'(r_count - 1'b1);
                                n_out_valid   = 1'b0;
                                n_state       = ST_POP;
                            end
                        end
                        REQ_POP_BACK: begin
                            if (is_empty) begin
                                n_status = STAT_UNDERFLOW;
                            end else begin
                                ram_cmd.re    = 1'b1;
                                ram_cmd.raddr = idx_down(r_tail);
                                n_tail        = idx_down(r_tail);
                                n_count       = t_cnt'(r_count - 1'b1);
                                n_out_valid   = 1'b0;
                                n_state       = ST_POP;
                            end
                        end
                        default: begin
                            n_status = STAT_OK;
                        end
                    endcase
                    n_empty = (n_count == '0);
                    n_full  = (n_count >= CNT_DEPTH);
                end
            end
            ST_POP: begin
                // RAM read data is ready; result slot is free here
                n_pop_value = from_word(i_rd_data);
                n_out_valid = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_pop_value <= n_pop_value;
        r_status    <= n_status;
        r_empty     <= n_empty;
        r_full      <= n_full;
    end

    assign o_ram_cmd       = ram_cmd;
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.pop_value = r_pop_value;
    assign o_rsp.status    = r_status;
    assign o_rsp.now_empty = r_empty;
    assign o_rsp.now_full  = r_full;

    // Occupancy never exceeds the store
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_DEPTH)
        else $error("occupancy above depth");

    // Empty or full deque has coinciding head and tail
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CNT_DEPTH) |-> (r_head == r_tail))
        else $error("head and tail disagree with occupancy");

    // A successful pop goes through the RAM read state
    a_pop_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_fire && !is_push && !is_empty) |=> (r_state == ST_POP && !r_out_valid))
        else $error("pop did not wait for RAM data");

    // A push produces its result on the next cycle
    a_push_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_fire && is_push) |=> r_out_valid)
        else $error("push result missing");

endmodule
`default_nettype wire

@@ sv/circular_deque_top.sv @@
// Top level of the circular deque: controller plus entry RAM.
//
//   channel  dir  handshake      payload
//   i_req    in   valid/ready    req_type[1:0], push_value[31:0]
//   o_rsp    out  valid/ready    pop_value[31:0], status[1:0], now_empty, now_full
//
// A push, or any rejected request, goes directly to the result register; a pop
// that succeeds first waits in the RAM read state for the registered RAM read data.
// Synchronous active-low reset clears head, tail and count; entries are not cleared.
// A result waits in the output register; a new item is taken in the cycle the
// result is taken, so o_rsp stalls throttle i_req directly.
`default_nettype none
module circular_deque_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cdq_req_if.sink   i_req,
    cdq_rsp_if.source o_rsp
);
    import cdq_pkg::*;

    t_ram_cmd ram_cmd;
    t_word    rd_data;

    // Pointer and count control, result register
    cdq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .o_ram_cmd (ram_cmd),
        .i_rd_data (rd_data)
    );

    // Entry store
    cdq_ram #(
        .DEPTH_P (DEPTH),
        .WIDTH_P (WORD_BITS),
        .AW_P    (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_cmd.we),
        .i_waddr (ram_cmd.waddr),
        .i_wdata (ram_cmd.wdata),
        .i_re    (ram_cmd.re),
        .i_raddr (ram_cmd.raddr),
        .o_rdata (rd_data)
    );

endmodule
`default_nettype wire
